// File: hdl/strip_hit_centroid_reconstruction_core_defines.svh
// Assertion macros shared by the strip hit centroid reconstruction RTL.
`ifndef STRIP_HIT_CENTROID_RECONSTRUCTION_CORE_DEFINES_SVH
`define STRIP_HIT_CENTROID_RECONSTRUCTION_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted.
`define SHCR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("shcr assertion failed");

// Clocked check that also holds during reset.
`define SHCR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("shcr assertion failed");

`else

`define SHCR_ASSERT(lbl, prop)
`define SHCR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: hdl/shcr_pkg.sv
// Shared constants and controller/datapath interface types.
package shcr_pkg;

    // Hits kept per array in one event
    localparam int MAX_HITS = 64;

    localparam int POS_W   = 16;                      // hit position, Q8.8 signed
    localparam int CNT_W   = $clog2(MAX_HITS + 1);    // per-array hit count
    localparam int SUM_W   = POS_W + CNT_W;           // per-array position sum
    localparam int BIT_W   = $clog2(SUM_W);           // divider step counter
    localparam int EVT_W   = 32;                      // event counters
    localparam int SIDE_W  = 2;
    localparam int NSIDE   = 4;

    // Strip array codes
    localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic              acc;        // input transaction taken this cycle
        logic              div_load;   // load divider with array 'side'
        logic              div_step;   // one restoring divide step
        logic              mean_save;  // store mean of array 'side'
        logic              emit;       // build result, bump counters, clear arrays
        logic [SIDE_W-1:0] side;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;                // output register can take a result
    } sts_t;

endpackage

// File: hdl/shcr_div.sv
// Unsigned restoring divider, one quotient bit per step.
module shcr_div (
    input  logic                        aclk,
    input  logic                        load,
    input  logic                        step,
    input  logic [shcr_pkg::SUM_W-1:0]  dividend,
    input  logic [shcr_pkg::CNT_W-1:0]  divisor,
    output logic [shcr_pkg::SUM_W-1:0]  quotient
);

    logic [shcr_pkg::SUM_W-1:0] quo_reg, quo_next;
    logic [shcr_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [shcr_pkg::CNT_W-1:0] dvs_reg;
    logic [shcr_pkg::CNT_W:0]   trial;
    logic [shcr_pkg::CNT_W:0]   diff;

    // Shift next dividend bit into the remainder and try a subtract
    always_comb begin
        trial    = {rem_reg, quo_reg[shcr_pkg::SUM_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (load) begin
            quo_next = dividend;
            rem_next = '0;
        end else if (step) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[shcr_pkg::CNT_W-1:0];
                quo_next = {quo_reg[shcr_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[shcr_pkg::CNT_W-1:0];
                quo_next = {quo_reg[shcr_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;

endmodule

// File: hdl/shcr_ctrl.sv
// Sequencer: accumulate hits, then four divides and the result hand-off.
`include "strip_hit_centroid_reconstruction_core_defines.svh"

module shcr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tlast,
    output logic            s_tready,
    input  shcr_pkg::sts_t  sts,
    output shcr_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_ACC  = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SAVE = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [shcr_pkg::BIT_W-1:0]  LAST_BIT  = shcr_pkg::BIT_W'(shcr_pkg::SUM_W - 1);
    localparam logic [shcr_pkg::SIDE_W-1:0] LAST_SIDE = shcr_pkg::SIDE_RIGHT;

    logic [2:0]                  state_reg, state_next;
    logic [shcr_pkg::SIDE_W-1:0] side_reg, side_next;
    logic [shcr_pkg::BIT_W-1:0]  bit_reg, bit_next;
    logic                        in_fire;

    assign s_tready = (state_reg == ST_ACC);
    assign in_fire  = s_tvalid && s_tready;

    // Next state and command decode
    always_comb begin
        state_next    = state_reg;
        side_next     = side_reg;
        bit_next      = bit_reg;
        cmd           = '0;
        cmd.side      = side_reg;
        unique case (state_reg)
            ST_ACC: begin
                cmd.acc = in_fire;
                if (in_fire && s_tlast) begin
                    side_next  = shcr_pkg::SIDE_BOTTOM;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                bit_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + 1'b1;
                if (bit_reg == LAST_BIT) begin
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE: begin
                cmd.mean_save = 1'b1;
                if (side_reg == LAST_SIDE) begin
                    state_next = ST_EMIT;
                end else begin
                    side_next  = side_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            side_reg  <= '0;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            side_reg  <= side_next;
            bit_reg   <= bit_next;
        end
    end

    // An accepted end-of-event transaction always starts the divide sequence
    `SHCR_ASSERT(a_eoe_starts_div, (in_fire && s_tlast) |=> (state_reg == ST_LOAD))
    // Divide step counter never runs past the dividend width
    `SHCR_ASSERT(a_bit_bound, (state_reg == ST_DIV) |-> (bit_reg <= LAST_BIT))
    // A result waiting for a free output register is emitted as soon as it is free
    `SHCR_ASSERT(a_emit_when_free,
        (state_reg == ST_EMIT && sts.out_free) |-> cmd.emit)

endmodule

// File: hdl/shcr_dp.sv
// Datapath: per-array sums and counts, shared divider, output register, counters.
`include "strip_hit_centroid_reconstruction_core_defines.svh"

module shcr_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  shcr_pkg::cmd_t                     cmd,
    output shcr_pkg::sts_t                     sts,
    input  logic [shcr_pkg::SIDE_W-1:0]        array_side,
    input  logic signed [shcr_pkg::POS_W-1:0]  hit_position,
    input  logic                               hit_present,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic signed [shcr_pkg::POS_W-1:0]  recon_x,
    output logic                               x_valid,
    output logic signed [shcr_pkg::POS_W-1:0]  recon_y,
    output logic                               y_valid,
    output logic [shcr_pkg::EVT_W-1:0]         events_total,
    output logic [shcr_pkg::EVT_W-1:0]         events_with_x,
    output logic [shcr_pkg::EVT_W-1:0]         events_with_y,
    output logic [shcr_pkg::EVT_W-1:0]         events_with_both
);

    localparam int POS_W = shcr_pkg::POS_W;
    localparam int SUM_W = shcr_pkg::SUM_W;
    localparam int CNT_W = shcr_pkg::CNT_W;
    localparam int EVT_W = shcr_pkg::EVT_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(shcr_pkg::MAX_HITS);

    logic signed [SUM_W-1:0] sum_reg   [shcr_pkg::NSIDE];
    logic signed [SUM_W-1:0] sum_next  [shcr_pkg::NSIDE];
    logic [CNT_W-1:0]        cnt_reg   [shcr_pkg::NSIDE];
    logic [CNT_W-1:0]        cnt_next  [shcr_pkg::NSIDE];
    logic signed [POS_W-1:0] mean_reg  [shcr_pkg::NSIDE];

    logic                    neg_reg;
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]        sel_mag;
    logic [SUM_W-1:0]        quotient;
    logic [SUM_W-1:0]        signed_quo;

    logic                    hx_a, hx_b, hy_a, hy_b, xv, yv;
    logic signed [POS_W-1:0] x_coord, y_coord;
    logic signed [POS_W:0]   x_pair, y_pair;

    logic                    m_valid_reg;
    logic [EVT_W-1:0]        ev_reg [4];

    // Per-array accumulate; a full array drops the hit, emit clears all
    always_comb begin
        for (int i = 0; i < shcr_pkg::NSIDE; i++) begin
            sum_next[i] = sum_reg[i];
            cnt_next[i] = cnt_reg[i];
            if (cmd.emit) begin
                sum_next[i] = '0;
                cnt_next[i] = '0;
            end else if (cmd.acc && hit_present && (array_side == shcr_pkg::SIDE_W'(i))
                         && (cnt_reg[i] < CNT_LIMIT)) begin
                sum_next[i] = sum_reg[i] + SUM_W'(hit_position);
                cnt_next[i] = cnt_reg[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < shcr_pkg::NSIDE; i++) begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < shcr_pkg::NSIDE; i++) begin
                sum_reg[i] <= sum_next[i];
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Divider operand: magnitude of the selected sum
    assign sel_sum = sum_reg[cmd.side];
    assign sel_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

    shcr_div u_div (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (sel_mag),
        .divisor  (cnt_reg[cmd.side]),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            neg_reg <= sel_sum[SUM_W-1];
        end
    end

    // Restore the sign: quotient truncates toward zero; an empty array means zero
    assign signed_quo = neg_reg ? (~quotient + 1'b1) : quotient;

    always_ff @(posedge aclk) begin
        if (cmd.mean_save) begin
            mean_reg[cmd.side] <= (cnt_reg[cmd.side] == '0) ? '0 : signed_quo[POS_W-1:0];
        end
    end

    // Combine array means into X and Y; pair average floors
    assign hx_a = (cnt_reg[shcr_pkg::SIDE_BOTTOM] != '0);
    assign hx_b = (cnt_reg[shcr_pkg::SIDE_TOP]    != '0);
    assign hy_a = (cnt_reg[shcr_pkg::SIDE_LEFT]   != '0);
    assign hy_b = (cnt_reg[shcr_pkg::SIDE_RIGHT]  != '0);
    assign xv   = hx_a || hx_b;
    assign yv   = hy_a || hy_b;

    assign x_pair = (POS_W+1)'(mean_reg[shcr_pkg::SIDE_BOTTOM])
                  + (POS_W+1)'(mean_reg[shcr_pkg::SIDE_TOP]);
    assign y_pair = (POS_W+1)'(mean_reg[shcr_pkg::SIDE_LEFT])
                  + (POS_W+1)'(mean_reg[shcr_pkg::SIDE_RIGHT]);

    always_comb begin
        priority if (hx_a && hx_b) x_coord = x_pair[POS_W:1];
        else if (hx_a)             x_coord = mean_reg[shcr_pkg::SIDE_BOTTOM];
        else if (hx_b)             x_coord = mean_reg[shcr_pkg::SIDE_TOP];
        else                       x_coord = '0;
        priority if (hy_a && hy_b) y_coord = y_pair[POS_W:1];
        else if (hy_a)             y_coord = mean_reg[shcr_pkg::SIDE_LEFT];
        else if (hy_b)             y_coord = mean_reg[shcr_pkg::SIDE_RIGHT];
        else                       y_coord = '0;
    end

    // Saturating event counters: total, with X, with Y, with both
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                ev_reg[i] <= '0;
            end
        end else if (cmd.emit) begin
            if (ev_reg[0] != '1)              ev_reg[0] <= ev_reg[0] + 1'b1;
            if (xv && ev_reg[1] != '1)        ev_reg[1] <= ev_reg[1] + 1'b1;
            if (yv && ev_reg[2] != '1)        ev_reg[2] <= ev_reg[2] + 1'b1;
            if (xv && yv && ev_reg[3] != '1)  ev_reg[3] <= ev_reg[3] + 1'b1;
        end
    end

    // Output register; counters read straight from their registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            recon_x <= x_coord;
            x_valid <= xv;
            recon_y <= y_coord;
            y_valid <= yv;
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign events_total     = ev_reg[0];
    assign events_with_x    = ev_reg[1];
    assign events_with_y    = ev_reg[2];
    assign events_with_both = ev_reg[3];
    assign sts.out_free     = !m_valid_reg || m_tready;

    // Per-array hit counts never pass the array limit
    `SHCR_ASSERT(a_cnt_limit,
        (cnt_reg[0] <= CNT_LIMIT) && (cnt_reg[1] <= CNT_LIMIT) &&
        (cnt_reg[2] <= CNT_LIMIT) && (cnt_reg[3] <= CNT_LIMIT))
    // Counter ordering: both <= with X/Y <= total
    `SHCR_ASSERT(a_ev_order,
        (ev_reg[3] <= ev_reg[1]) && (ev_reg[3] <= ev_reg[2]) &&
        (ev_reg[1] <= ev_reg[0]) && (ev_reg[2] <= ev_reg[0]))
    // Arrays are empty right after a result is built
    `SHCR_ASSERT(a_clear_on_emit, cmd.emit |=>
        (cnt_reg[0] == '0) && (cnt_reg[1] == '0) &&
        (cnt_reg[2] == '0) && (cnt_reg[3] == '0))

endmodule

// File: hdl/strip_hit_centroid_reconstruction_core.sv
// Top level: strip hit centroid reconstruction core.
//
//  channel  dir  tdata                                     tuser / tlast
//  s_       in   hit_position[15:0]                        tuser: array_side, hit_present
//                                                          tlast: end_of_event
//  m_       out  recon_x, recon_y, four event counters     tuser: x_valid, y_valid
//
//  A hit transaction is taken while s_tready is high; hits stream back to back within an event.
//  After end of event the shared one-bit-per-cycle divider runs for each of the
//  four arrays in turn (load, divide steps, save), then the result is loaded once the output register is free.
//  s_tready stays low from the end-of-event transaction until the result is loaded;
//  a result still waiting on m_tready stalls only the next event's end.
//  Reset (aresetn low at a clock edge) clears sums, counts, counters and m_tvalid.
module strip_hit_centroid_reconstruction_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] hit_position
    input  logic [2:0]   s_tuser,   // [1:0] array_side, [2] hit_present
    input  logic         s_tlast,   // end_of_event
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // [15:0] recon_x, [31:16] recon_y, [63:32] events_total,
                                    // [95:64] events_with_x, [127:96] events_with_y,
                                    // [159:128] events_with_both
    output logic [1:0]   m_tuser    // [0] x_valid, [1] y_valid
);

    shcr_pkg::cmd_t cmd;
    shcr_pkg::sts_t sts;

    logic signed [shcr_pkg::POS_W-1:0] recon_x;
    logic signed [shcr_pkg::POS_W-1:0] recon_y;
    logic                              x_valid;
    logic                              y_valid;
    logic [shcr_pkg::EVT_W-1:0]        events_total;
    logic [shcr_pkg::EVT_W-1:0]        events_with_x;
    logic [shcr_pkg::EVT_W-1:0]        events_with_y;
    logic [shcr_pkg::EVT_W-1:0]        events_with_both;

    shcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    shcr_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .array_side       (s_tuser[1:0]),
        .hit_position     (s_tdata),
        .hit_present      (s_tuser[2]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .recon_x          (recon_x),
        .x_valid          (x_valid),
        .recon_y          (recon_y),
        .y_valid          (y_valid),
        .events_total     (events_total),
        .events_with_x    (events_with_x),
        .events_with_y    (events_with_y),
        .events_with_both (events_with_both)
    );

    // Pack result fields, lowest field first
    assign m_tdata = {events_with_both, events_with_y, events_with_x, events_total,
                      recon_y, recon_x};
    assign m_tuser = {y_valid, x_valid};

endmodule
